>>> hw/rtl/dmf_pkg.sv
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared types and constants of the duplicate message filter: the token that
// walks the cell chain, the insert broadcast and the result record.
// ----------------------------------------------------------------------------
package dmf_pkg;

  localparam logic       OP_ARRIVE  = 1'b0;
  localparam logic       OP_CLEAN   = 1'b1;
  localparam logic [7:0] CNT_MAX    = 8'd255;
  localparam logic [7:0] CNT_ONE    = 8'd1;
  localparam logic [6:0] REM_MAX    = 7'd127;
  localparam logic [31:0] KEEP_RESET = 32'd5000;

  typedef struct packed {
    logic        active;
    logic        op;
    logic [31:0] id;
    logic [47:0] tm;
    logic        exp_ok;
    logic        hit;
    logic        free;
    logic [7:0]  cnt;
    logic [6:0]  removed;
  } dmf_tok_t;

  typedef struct packed {
    logic        en;
    logic [31:0] id;
    logic [47:0] tm;
  } dmf_ins_t;

  typedef struct packed {
    logic        fresh;
    logic [7:0]  cnt;
    logic        full;
    logic [6:0]  removed;
    logic [31:0] ack;
  } dmf_res_t;

endpackage

>>> hw/rtl/dmf_cell.sv
// ----------------------------------------------------------------------------
// dmf_cell
// One table entry. Checks the passing token against the stored id or expiry
// threshold, updates the entry and hands the token to the next cell.
// ----------------------------------------------------------------------------
module dmf_cell
  import dmf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dmf_tok_t tok_i,
  input  dmf_ins_t ins_i,
  output dmf_tok_t tok_o
);

  dmf_tok_t    tok_q, tok_d;
  logic        valid_q, valid_d;
  logic        claim_q, claim_d;
  logic [31:0] id_q, id_d;
  logic [47:0] tm_q, tm_d;
  logic [7:0]  cnt_q, cnt_d;

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    claim_d = claim_q;
    id_d    = id_q;
    tm_d    = tm_q;
    cnt_d   = cnt_q;
    if (tok_i.active) begin
      claim_d = 1'b0;
      if (tok_i.op == OP_ARRIVE) begin
        if (valid_q && id_q == tok_i.id && !tok_i.hit) begin
          if (cnt_q != CNT_MAX) begin
            cnt_d = cnt_q + CNT_ONE;
          end
          tok_d.hit = 1'b1;
          tok_d.cnt = (cnt_q != CNT_MAX) ? cnt_q + CNT_ONE : cnt_q;
        end
        if (!valid_q && !tok_i.free) begin
          claim_d    = 1'b1;
          tok_d.free = 1'b1;
        end
      end else begin
        if (valid_q && tok_i.exp_ok && tm_q < tok_i.tm) begin
          valid_d = 1'b0;
          if (tok_i.removed != REM_MAX) begin
            tok_d.removed = tok_i.removed + 7'd1;
          end
        end
      end
    end else if (ins_i.en && claim_q) begin
      valid_d = 1'b1;
      claim_d = 1'b0;
      id_d    = ins_i.id;
      tm_d    = ins_i.tm;
      cnt_d   = CNT_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      valid_q <= 1'b0;
      claim_q <= 1'b0;
    end else begin
      tok_q   <= tok_d;
      valid_q <= valid_d;
      claim_q <= claim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    tm_q  <= tm_d;
    cnt_q <= cnt_d;
  end

  assign tok_o = tok_q;

endmodule

>>> hw/rtl/duplicate_message_filter.sv
// Result path: the token passes the ENTRIES cell registers, then the result
// is held in the pending register and then in the output register.
// One item at a time: the token walks the chain one entry per cycle, and a new
// item is taken once the previous result has moved into the output register.
// Reset: asynchronous, active low; empties the table, keep_time = 5000.
// ----------------------------------------------------------------------------
// duplicate_message_filter
// Id table for duplicate suppression with time-based expiry, built as a row
// of entry cells that a request token passes through.
// ----------------------------------------------------------------------------
module duplicate_message_filter
  import dmf_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_keep_time_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_op_i,
  input  logic [31:0] in_message_id_i,
  input  logic [47:0] in_now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_fresh_o,
  output logic [7:0]  out_reception_count_o,
  output logic        out_table_full_o,
  output logic [6:0]  out_removed_count_o,
  output logic [31:0] out_ack_id_o
);

  logic        busy_q;
  logic        pend_valid_q;
  logic        out_valid_q;
  logic [31:0] keep_q;
  dmf_res_t    pend_q, out_q, res;
  dmf_tok_t    tok_in, tok_exit;
  dmf_tok_t    tok_w [ENTRIES+1];
  dmf_ins_t    ins;
  logic [48:0] diff;
  logic        accept;
  logic        out_load;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign accept      = in_valid_i && !busy_q;
  assign out_load    = pend_valid_q && (!out_valid_q || !out_stall_i);
  assign diff        = {1'b0, in_now_ms_i} - {17'd0, keep_q};

  always_comb begin
    tok_in = '0;
    if (accept) begin
      tok_in.active = 1'b1;
      tok_in.op     = in_op_i;
      tok_in.id     = in_message_id_i;
      tok_in.tm     = (in_op_i == OP_CLEAN) ? diff[47:0] : in_now_ms_i;
      tok_in.exp_ok = !diff[48];
    end
  end

  assign tok_w[0] = tok_in;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    dmf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_w[g]),
      .ins_i  (ins),
      .tok_o  (tok_w[g+1])
    );
  end

  assign tok_exit = tok_w[ENTRIES];

  always_comb begin
    ins.en = tok_exit.active && tok_exit.op == OP_ARRIVE && !tok_exit.hit && tok_exit.free;
    ins.id = tok_exit.id;
    ins.tm = tok_exit.tm;
    res    = '0;
    if (tok_exit.op == OP_ARRIVE) begin
      res.fresh = !tok_exit.hit;
      res.cnt   = tok_exit.hit ? tok_exit.cnt : CNT_ONE;
      res.full  = !tok_exit.hit && !tok_exit.free;
      res.ack   = tok_exit.id;
    end else begin
      res.removed = tok_exit.removed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q       <= KEEP_RESET;
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        keep_q <= cfg_keep_time_i;
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (out_load) begin
        busy_q <= 1'b0;
      end
      if (tok_exit.active) begin
        pend_valid_q <= 1'b1;
      end else if (out_load) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_exit.active) begin
      pend_q <= res;
    end
    if (out_load) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_fresh_o           = out_q.fresh;
  assign out_reception_count_o = out_q.cnt;
  assign out_table_full_o      = out_q.full;
  assign out_removed_count_o   = out_q.removed;
  assign out_ack_id_o          = out_q.ack;

`ifndef SYNTHESIS
  a_idle_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !tok_exit.active)
    else $error("token left the chain while idle");
  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> busy_q)
    else $error("pending result without a busy item");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_exit.active |-> !pend_valid_q)
    else $error("pending result overwritten");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && !accept)
    else $error("item accepted while another is in flight");
`endif

endmodule
